// ===== rtl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int FW_W        = 11;
  localparam int FH_W        = 12;
  localparam int ROW_W       = FH_W;
  localparam int INC_W       = ((COL_W > FW_W) ? COL_W : FW_W) + 1;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int CFG_W       = FH_W;
  localparam int CFG_IDX_W   = 1;
  localparam int SUM_W       = 12;
  localparam int PROD_W      = 24;
  localparam int OFIFO_DEPTH = 5;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int CREDIT_W    = $clog2(OFIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // reciprocal multipliers for the divide by 3 and by 9
  localparam logic [SUM_W-1:0] RECIP_3       = 12'd2731;
  localparam int               RECIP_3_SHIFT = 13;
  localparam logic [SUM_W-1:0] RECIP_9       = 12'd1821;
  localparam int               RECIP_9_SHIFT = 14;

  typedef enum logic [1:0] {
    DIV_ONE   = 2'd0,
    DIV_THREE = 2'd1,
    DIV_NINE  = 2'd2
  } bb3_div_t;

  typedef logic [2:0][2:0][PIX_W-1:0] bb3_window_t;

  typedef struct packed {
    logic row_above;
    logic row_below;
    logic col_left;
    logic col_right;
    logic last;
  } bb3_mask_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } bb3_result_t;

endpackage

// ===== rtl/bb3_ram.sv =====
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bb3_mean.sv =====
// ----------------------------------------------------------------------------
// bb3_mean
// Masked 3x3 sum per channel and rounded mean; the sums are registered before the reciprocal divide.
// ----------------------------------------------------------------------------
module bb3_mean (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  bb3_pkg::bb3_window_t win,
  input  bb3_pkg::bb3_mask_t   mask,
  output logic                valid_out,
  output bb3_pkg::bb3_result_t result
);
  import bb3_pkg::*;

  logic [2:0]             row_ok;
  logic [2:0]             col_ok;
  logic [1:0]             cnt_r;
  logic [1:0]             cnt_c;
  logic [SUM_W-1:0]       sum [3];
  logic [2:0]             add;
  logic [1:0]             shift;
  bb3_div_t               kind;
  logic [SUM_W-1:0]       y_next [3];

  logic                   m_valid;
  logic [SUM_W-1:0]       m_y [3];
  bb3_div_t               m_kind;
  logic                   m_last;
  logic [SUM_W-1:0]       mult;
  logic [PROD_W-1:0]      prod [3];

  always_comb begin
    row_ok = {mask.row_below, 1'b1, mask.row_above};
    col_ok = {mask.col_right, 1'b1, mask.col_left};
    cnt_r  = 2'(mask.row_above) + 2'(mask.row_below);
    cnt_c  = 2'(mask.col_left) + 2'(mask.col_right);
  end

  // n = (cnt_r+1)*(cnt_c+1); mean = floor((2*sum + n) / (2*n))
  always_comb begin
    case ({cnt_r, cnt_c})
      4'b0000: begin add = 3'd0; shift = 2'd0; kind = DIV_ONE;   end
      4'b0001,
      4'b0100: begin add = 3'd1; shift = 2'd1; kind = DIV_ONE;   end
      4'b0010,
      4'b1000: begin add = 3'd1; shift = 2'd0; kind = DIV_THREE; end
      4'b0101: begin add = 3'd2; shift = 2'd2; kind = DIV_ONE;   end
      4'b0110,
      4'b1001: begin add = 3'd3; shift = 2'd1; kind = DIV_THREE; end
      4'b1010: begin add = 3'd4; shift = 2'd0; kind = DIV_NINE;  end
      default: begin add = 3'd0; shift = 2'd0; kind = DIV_ONE;   end
    endcase
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            sum[ch] = sum[ch] + SUM_W'(win[r][c][ch*CH_W +: CH_W]);
          end
        end
      end
      y_next[ch] = (sum[ch] + SUM_W'(add)) >> shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in) begin
      m_y    <= y_next;
      m_kind <= kind;
      m_last <= mask.last;
    end
  end

  always_comb begin
    case (m_kind)
      DIV_THREE: mult = RECIP_3;
      DIV_NINE:  mult = RECIP_9;
      default:   mult = '0;
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(m_y[ch]) * PROD_W'(mult);
      case (m_kind)
        DIV_THREE: result.pix[ch*CH_W +: CH_W] = prod[ch][RECIP_3_SHIFT +: CH_W];
        DIV_NINE:  result.pix[ch*CH_W +: CH_W] = prod[ch][RECIP_9_SHIFT +: CH_W];
        default:   result.pix[ch*CH_W +: CH_W] = m_y[ch][CH_W-1:0];
      endcase
    end
    result.last = m_last;
    valid_out   = m_valid;
  end

endmodule

// ===== rtl/box_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3
// Streaming 3x3 box blur over raster-order RGB frames.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_ready is high and returns the blurred
// frame one row plus one pixel behind the input. A taken request is registered
// at the line buffers, the window and the mean before its result is queued;
// the five-entry queue lets requests keep flowing while results wait, and
// input ready drops only while five results are outstanding. Two line buffers
// share one RAM with one write and one read port; their contents need no
// clearing after reset. After the last pixel of a frame send drain requests
// (command = 1) until frame_end is seen. Write frame_width and frame_height
// only while no request is in flight; a write restarts the frame.
module box_blur_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [7:0]                    red_in,
  input  logic [7:0]                    green_in,
  input  logic [7:0]                    blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    red_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    blue_out,
  output logic                          frame_end
);
  import bb3_pkg::*;

  logic [FW_W-1:0]     frame_width;
  logic [FH_W-1:0]     frame_height;
  logic [FW_W-1:0]     eff_w;
  logic [FH_W-1:0]     eff_h;

  logic [COL_W-1:0]    icol;
  logic [ROW_W:0]      irow;
  logic [COL_W-1:0]    ocol;
  logic [ROW_W-1:0]    orow;

  logic                accept;
  logic                complete;
  logic                take;
  logic                emit;
  logic [INC_W-1:0]    icol_inc;
  logic                icol_wrap;
  logic [INC_W-1:0]    ocol_inc;
  logic                ocol_last;
  logic [ROW_W:0]      orow_inc;
  logic                orow_last;
  logic [PIX_W-1:0]    pix_next;
  bb3_mask_t           mask_next;

  logic                b_valid;
  logic                b_emit;
  logic                b_fwd;
  logic [COL_W-1:0]    b_col;
  logic [PIX_W-1:0]    b_pix;
  bb3_mask_t           b_mask;
  logic [PIX_W-1:0]    f_older;
  logic [PIX_W-1:0]    f_newer;
  logic [2*PIX_W-1:0]  line_rd;
  logic [PIX_W-1:0]    top;
  logic [PIX_W-1:0]    mid;

  bb3_window_t         win;
  logic                c_valid;
  bb3_mask_t           c_mask;

  logic                m_push;
  bb3_result_t         m_result;

  bb3_result_t         ofifo [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wp;
  logic [OFIFO_AW-1:0] rp;
  logic [CREDIT_W-1:0] count;
  logic [CREDIT_W-1:0] credit;
  logic                pop;

  // effective frame size
  always_comb begin
    if (frame_width == '0) begin
      eff_w = FW_W'(1);
    end else if (INC_W'(frame_width) > INC_W'(MAX_WIDTH)) begin
      eff_w = FW_W'(MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  always_comb begin
    accept    = in_valid & in_ready;
    complete  = irow >= {1'b0, eff_h};
    take      = accept & ~(command & ~complete);
    emit      = (irow >= (ROW_W+1)'(2)) | ((irow == (ROW_W+1)'(1)) & (icol != '0));
    icol_inc  = INC_W'(icol) + INC_W'(1);
    icol_wrap = icol_inc >= INC_W'(eff_w);
    ocol_inc  = INC_W'(ocol) + INC_W'(1);
    ocol_last = ocol_inc >= INC_W'(eff_w);
    orow_inc  = (ROW_W+1)'(orow) + (ROW_W+1)'(1);
    orow_last = orow_inc >= {1'b0, eff_h};
    pix_next  = complete ? '0 : {red_in, green_in, blue_in};
    mask_next.row_above = orow != '0;
    mask_next.row_below = ~orow_last;
    mask_next.col_left  = ocol != '0;
    mask_next.col_right = ~ocol_last;
    mask_next.last      = orow_last & ocol_last;
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(480);
      icol         <= '0;
      irow         <= '0;
      ocol         <= '0;
      orow         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
      icol <= '0;
      irow <= '0;
      ocol <= '0;
      orow <= '0;
    end else if (take) begin
      if (emit && mask_next.last) begin
        icol <= '0;
        irow <= '0;
        ocol <= '0;
        orow <= '0;
      end else begin
        if (icol_wrap) begin
          icol <= '0;
          irow <= irow + (ROW_W+1)'(1);
        end else begin
          icol <= COL_W'(icol_inc);
        end
        if (emit) begin
          if (ocol_last) begin
            ocol <= '0;
            orow <= ROW_W'(orow_inc);
          end else begin
            ocol <= COL_W'(ocol_inc);
          end
        end
      end
    end
  end

  // line buffers: older row in the upper half, newer row in the lower half
  bb3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata ({mid, b_pix}),
    .re    (take),
    .raddr (icol),
    .rdata (line_rd)
  );

  // forward the write that lands on the same edge as the read
  always_comb begin
    top = b_fwd ? f_older : line_rd[2*PIX_W-1:PIX_W];
    mid = b_fwd ? f_newer : line_rd[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_col   <= icol;
      b_pix   <= pix_next;
      b_emit  <= emit;
      b_mask  <= mask_next;
      b_fwd   <= b_valid && (b_col == icol);
      f_older <= mid;
      f_newer <= b_pix;
    end
  end

  // advance the window
  always_ff @(posedge clk) begin
    if (b_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= b_pix;
      c_mask    <= b_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid & b_emit;
    end
  end

  bb3_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (c_valid),
    .win       (win),
    .mask      (c_mask),
    .valid_out (m_push),
    .result    (m_result)
  );

  // output queue
  always_comb begin
    out_valid = count != '0;
    pop       = out_valid & out_ready;
    in_ready  = credit < CREDIT_W'(OFIFO_DEPTH);
    {red_out, green_out, blue_out} = ofifo[rp].pix;
    frame_end = ofifo[rp].last;
  end

  always_ff @(posedge clk) begin
    if (m_push) begin
      ofifo[wp] <= m_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      count  <= '0;
      credit <= '0;
    end else begin
      if (m_push) begin
        wp <= (wp == OFIFO_AW'(OFIFO_DEPTH - 1)) ? '0 : wp + OFIFO_AW'(1);
      end
      if (pop) begin
        rp <= (rp == OFIFO_AW'(OFIFO_DEPTH - 1)) ? '0 : rp + OFIFO_AW'(1);
      end
      count  <= count + CREDIT_W'(m_push) - CREDIT_W'(pop);
      credit <= credit + CREDIT_W'(take & emit) - CREDIT_W'(pop);
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CREDIT_W'(OFIFO_DEPTH))
    else $error("outstanding results exceed queue depth");

  a_count_le_credit: assert property (@(posedge clk) disable iff (rst)
    count <= credit)
    else $error("queue holds more results than were requested");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    m_push |-> count < CREDIT_W'(OFIFO_DEPTH))
    else $error("push into full output queue");

  a_emit_reaches_mean: assert property (@(posedge clk) disable iff (rst)
    (take && emit) |=> ##1 c_valid)
    else $error("emitting request lost before the mean stage");

endmodule

// ===== bench/tb_box_blur_3x3.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3
// Self-checking bench for the streaming 3x3 box blur. A line-buffer model
// inside the bench computes the rounded neighbor means and the frame_end
// flag of every result. Each result leaving the block is compared
// field by field against the oldest prediction. The stimulus covers
// out-of-range and extreme frame sizes, stray drains, pixels sent in place
// of drains, and frames cut short by a register write. It runs under
// several idle and stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3;
  import bb3_pkg::*;

  localparam logic CMD_PIXEL       = 1'b0;
  localparam logic CMD_DRAIN       = 1'b1;
  localparam int   SETTLE_CYCLES   = 12;
  localparam int   IDLE_LIMIT      = 5000;
  localparam int   HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         wait_empty;
  } px_request_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } blur_px_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 command   = CMD_PIXEL;
  logic [7:0]           red_in    = '0;
  logic [7:0]           green_in  = '0;
  logic [7:0]           blue_in   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           red_out;
  logic [7:0]           green_out;
  logic [7:0]           blue_out;
  logic                 frame_end;

  box_blur_3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line-buffer model of the blur
  logic [FW_W-1:0]  width_reg  = 11'd640;
  logic [FH_W-1:0]  height_reg = 12'd480;
  logic [PIX_W-1:0] older_line [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0] newer_line [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0] window [3][3] = '{default: '0};
  int               in_col  = 0;
  int               in_row  = 0;
  int               out_col = 0;
  int               out_row = 0;

  blur_px_t    blurred_expected [$];
  px_request_t pending_requests [$];
  px_request_t offered;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int requests_queued = 0;
  int requests_taken  = 0;
  int fail_count      = 0;
  int hold_left       = 0;
  bit hold_armed      = 1'b0;
  bit hold_used       = 1'b0;
  int quiet_cycles    = 0;

  function automatic int frame_cols();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int frame_rows();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void blur_step(px_request_t rq);
    int               w;
    int               h;
    int               col;
    int               n;
    int               r;
    int               c;
    int               k;
    int               sum [3];
    logic [7:0]       mean [3];
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    bit               complete;
    bit               emit;
    bit               last;
    bit               row_ok [3];
    bit               col_ok [3];
    blur_px_t         px;
    w = frame_cols();
    h = frame_rows();
    complete = (in_row >= h);
    if (rq.cmd == CMD_DRAIN && !complete) return;
    pix = complete ? '0 : {rq.red, rq.green, rq.blue};
    col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    top = older_line[col];
    mid = newer_line[col];
    older_line[col] = mid;
    newer_line[col] = pix;
    for (r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = top;
    window[1][2] = mid;
    window[2][2] = pix;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    row_ok[0] = (out_row >= 1);
    row_ok[1] = 1'b1;
    row_ok[2] = (out_row + 1 < h);
    col_ok[0] = (out_col >= 1);
    col_ok[1] = 1'b1;
    col_ok[2] = (out_col + 1 < w);
    n = 0;
    sum = '{0, 0, 0};
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          n++;
          for (k = 0; k < 3; k++) sum[k] += window[r][c][(2 - k) * CH_W +: CH_W];
        end
      end
    end
    // round half up
    for (k = 0; k < 3; k++) mean[k] = 8'((2 * sum[k] + n) / (2 * n));
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    px.red       = mean[0];
    px.green     = mean[1];
    px.blue      = mean[2];
    px.frame_end = last;
    blurred_expected.push_back(px);
    if (last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        blur_step(offered);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_requests[0].wait_empty && blurred_expected.size() != 0)) begin
          offered = pending_requests.pop_front();
          in_valid <= 1'b1;
          command  <= offered.cmd;
          red_in   <= offered.red;
          green_in <= offered.green;
          blue_in  <= offered.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output backpressure
  always @(posedge clk) begin
    blur_px_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (blurred_expected.size() == 0) begin
          $error("unexpected result: rgb %0d %0d %0d frame_end %0b",
                 red_out, green_out, blue_out, frame_end);
          fail_count++;
        end else begin
          want = blurred_expected.pop_front();
          check_field("red_out", want.red, red_out);
          check_field("green_out", want.green, green_out);
          check_field("blue_out", want.blue, blue_out);
          check_field("frame_end", 8'(want.frame_end), 8'(frame_end));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_armed && !hold_used) begin
        hold_left <= HOLD_OFF_CYCLES;
        hold_used <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_channel(bit extreme);
    if (extreme) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic void push_request(logic cmd, bit extreme, bit wait_empty);
    px_request_t rq;
    rq.cmd        = cmd;
    rq.red        = pick_channel(extreme);
    rq.green      = pick_channel(extreme);
    rq.blue       = pick_channel(extreme);
    rq.wait_empty = wait_empty;
    pending_requests.push_back(rq);
    requests_queued++;
  endfunction

  // full frame, then the drains that flush it
  function automatic void queue_frame(bit extreme, int noise_pct, bit pause_first);
    int i;
    int w;
    int h;
    w = frame_cols();
    h = frame_rows();
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) push_request(CMD_DRAIN, extreme, 1'b0);
      push_request(CMD_PIXEL, extreme, pause_first && i == 0);
    end
    for (i = 0; i <= w; i++) begin
      push_request(($urandom_range(99) < noise_pct) ? CMD_PIXEL : CMD_DRAIN, extreme, 1'b0);
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    if (idx == REG_FRAME_WIDTH) width_reg = FW_W'(value);
    else height_reg = FH_W'(value);
    restart_frame();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (requests_taken != requests_queued || blurred_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph;
    int k;
    int pixels;
    bit restart_due;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single pixel frame from zero registers, with stray drain and pixel drains
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    queue_frame(1'b1, 100, 1'b0);
    settle();

    // corners, edges and center at zero and full-scale values
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    queue_frame(1'b1, 0, 1'b0);
    settle();

    // cut a frame short and restart it
    repeat (4) push_request(CMD_PIXEL, 1'b1, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    queue_frame(1'b1, 0, 1'b0);
    settle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_armed     = 1'b1;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      restart_due = 1'b1;
      for (k = 0; k < 9; k++) begin
        if (restart_due || (ph != 0 && $urandom_range(3) == 0)) begin
          settle();
          write_reg(REG_FRAME_WIDTH, $urandom_range(6, 1));
          write_reg(REG_FRAME_HEIGHT, $urandom_range(5, 1));
          restart_due = 1'b0;
        end
        if (ph != 0 && $urandom_range(9) == 0 && frame_cols() * frame_rows() > 1) begin
          pixels = $urandom_range(frame_cols() * frame_rows() - 1, 1);
          repeat (pixels) push_request(CMD_PIXEL, 1'b0, 1'b0);
          restart_due = 1'b1;
        end else begin
          queue_frame(1'b0, 5, $urandom_range(3) == 0);
        end
      end
      settle();
    end

    // wide and tall frames, no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_FRAME_WIDTH, 24);
    write_reg(REG_FRAME_HEIGHT, 3);
    queue_frame(1'b0, 0, 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 12);
    queue_frame(1'b0, 0, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
